@@ hw/rtl/hntm_pkg.sv @@
// shared types, constants and functions of the two-nearest hamming matcher
package hntm_pkg;

	// fixed field widths
	localparam int DESC_WORD_W = 64;
	localparam int WORD_IDX_W  = 2;
	localparam int ITEM_IDX_W  = 9;
	localparam int OUT_DIST_W  = 9;
	localparam int RATIO_W     = 10;
	localparam int FRAC_BITS   = 8;
	localparam int POP_W       = 7;

	// stream bus widths, padded to whole bytes
	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 40;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 10;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELL  = 1'd1;
	localparam logic [RATIO_W-1:0]   RATIO_RESET = 10'd205;
	localparam logic                 CELL_RESET  = 1'b1;

	// request kinds carried in tuser
	localparam logic REQ_TRAIN = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// distances above this saturate on the output
	localparam logic [OUT_DIST_W-1:0] DIST_SAT = 9'd511;

	// low bit of every 2-bit cell
	localparam logic [DESC_WORD_W-1:0] CELL_MASK = 64'h5555_5555_5555_5555;

	// parameter defaults
	localparam int KEYPOINTS_DEFAULT  = 512;
	localparam int DESC_BYTES_DEFAULT = 32;

	// control tag that travels with each train read
	typedef struct packed {
		logic valid;
		logic last;
	} scan_tag_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	// number of set bits in one descriptor word, as a tree of partial sums
	function automatic logic [POP_W-1:0] popcount64(input logic [DESC_WORD_W-1:0] x);
		logic [DESC_WORD_W-1:0] v;
		v = x - ((x >> 1) & CELL_MASK);
		v = (v & 64'h3333_3333_3333_3333) + ((v >> 2) & 64'h3333_3333_3333_3333);
		v = (v + (v >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
		v = v + (v >> 8);
		v = v + (v >> 16);
		v = v + (v >> 32);
		return v[POP_W-1:0];
	endfunction

endpackage

@@ hw/rtl/hntm_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
module hntm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/hntm_dist.sv @@
// per-word difference lanes and distance sum, two pipeline stages
module hntm_dist #(
	parameter int KEYPOINTS  = hntm_pkg::KEYPOINTS_DEFAULT,
	parameter int DESC_BYTES = hntm_pkg::DESC_BYTES_DEFAULT
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         cell_mode,
	input  logic [(DESC_BYTES+7)/8-1:0][hntm_pkg::DESC_WORD_W-1:0] query,
	input  logic [(DESC_BYTES+7)/8-1:0][hntm_pkg::DESC_WORD_W-1:0] train,
	input  hntm_pkg::scan_tag_t                          tag_s1,
	input  logic [$clog2(KEYPOINTS)-1:0]                 idx_s1,
	output hntm_pkg::scan_tag_t                          tag_s3,
	output logic [$clog2(KEYPOINTS)-1:0]                 idx_s3,
	output logic [$clog2(DESC_BYTES*8+1)-1:0]            dist_s3
);

	localparam int WORDS  = (DESC_BYTES + 7) / 8;
	localparam int TAIL   = DESC_BYTES % 8;
	localparam int KEY_AW = $clog2(KEYPOINTS);
	localparam int DIST_W = $clog2(DESC_BYTES * 8 + 1);

	logic [WORDS-1:0][hntm_pkg::POP_W-1:0] cnt_s2;
	hntm_pkg::scan_tag_t                   tag_s2;
	logic [KEY_AW-1:0]                     idx_s2;
	logic [DIST_W-1:0]                     sum;

	// one lane per descriptor word: xor, tail mask, optional cell fold, count
	for (genvar w = 0; w < WORDS; w++) begin : g_lane
		localparam logic [hntm_pkg::DESC_WORD_W-1:0] MASK =
			(w == WORDS - 1 && TAIL != 0) ? ((64'd1 << (TAIL * 8)) - 64'd1) : '1;
		logic [hntm_pkg::DESC_WORD_W-1:0] diff;
		logic [hntm_pkg::DESC_WORD_W-1:0] folded;

		assign diff   = (query[w] ^ train[w]) & MASK;
		assign folded = cell_mode ? ((diff | (diff >> 1)) & hntm_pkg::CELL_MASK) : diff;

		always_ff @(posedge clk) begin
			cnt_s2[w] <= hntm_pkg::popcount64(folded);
		end
	end

	// stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2 <= idx_s1;
	end

	// add the lane counts
	always_comb begin
		sum = '0;
		for (int w = 0; w < WORDS; w++) begin
			sum = sum + DIST_W'(cnt_s2[w]);
		end
	end

	// stage 3 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
		end else begin
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s3  <= idx_s2;
		dist_s3 <= sum;
	end

endmodule

@@ hw/rtl/hntm_rank.sv @@
// keeps the two smallest distances of a scan, earlier index wins a tie
module hntm_rank #(
	parameter int KEYPOINTS  = hntm_pkg::KEYPOINTS_DEFAULT,
	parameter int DESC_BYTES = hntm_pkg::DESC_BYTES_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  hntm_pkg::scan_tag_t               tag,
	input  logic [$clog2(KEYPOINTS)-1:0]      idx,
	input  logic [$clog2(DESC_BYTES*8+1)-1:0] dist_in,
	output logic [$clog2(DESC_BYTES*8+1)-1:0] best,
	output logic [$clog2(DESC_BYTES*8+1)-1:0] second,
	output logic [$clog2(KEYPOINTS)-1:0]      best_idx,
	output logic                              done
);

	localparam int KEY_AW = $clog2(KEYPOINTS);
	localparam int DIST_W = $clog2(DESC_BYTES * 8 + 1);

	logic              have_best_q;
	logic              have_second_q;
	logic [DIST_W-1:0] best_q;
	logic [DIST_W-1:0] second_q;
	logic [KEY_AW-1:0] best_idx_q;
	logic              done_q;

	// running top-two update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_best_q   <= 1'b0;
			have_second_q <= 1'b0;
			best_q        <= '1;
			second_q      <= '1;
			best_idx_q    <= '0;
			done_q        <= 1'b0;
		end else begin
			done_q <= tag.valid && tag.last;
			if (start) begin
				have_best_q   <= 1'b0;
				have_second_q <= 1'b0;
			end else if (tag.valid) begin
				if (!have_best_q || dist_in < best_q) begin
					if (have_best_q) begin
						second_q      <= best_q;
						have_second_q <= 1'b1;
					end
					best_q      <= dist_in;
					best_idx_q  <= idx;
					have_best_q <= 1'b1;
				end else if (!have_second_q || dist_in < second_q) begin
					second_q      <= dist_in;
					have_second_q <= 1'b1;
				end
			end
		end
	end

	assign best     = best_q;
	assign second   = second_q;
	assign best_idx = best_idx_q;
	assign done     = done_q;

endmodule

@@ hw/rtl/hamming_two_nearest_matcher.sv @@
// top level of the two-nearest hamming matcher: sequencer, stores, ratio test, result register
//
// Train descriptors are loaded one 64-bit word per request (tuser low);
// query words (tuser high) are latched the same way. The request carrying
// the last word of a query starts a scan that reads one whole train
// descriptor per cycle, all words side by side from one ram per word
// position; each entry then passes through read, count, sum and rank,
// and the ratio test follows the rank. No request is taken during a scan.
// A finished result waits in the output register while train loads and
// further query words go on; the next scan result waits for it to be
// taken. A failing ratio test still gives a result, with tuser low. Train
// entries must be written before a query is matched against them.
module hamming_two_nearest_matcher #(
	parameter int KEYPOINTS  = hntm_pkg::KEYPOINTS_DEFAULT,
	parameter int DESC_BYTES = hntm_pkg::DESC_BYTES_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [hntm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hntm_pkg::CFG_DATA_W-1:0]   cfg_data,
	// request stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// desc_word [63:0], word_index [65:64], item_index [74:66], zero pad
	input  logic [hntm_pkg::S_TDATA_W-1:0]    s_tdata,
	// req_type [0]
	input  logic                              s_tuser,
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// query_index [8:0], train_index [17:9], best_distance [26:18],
	// second_distance [35:27], zero pad
	output logic [hntm_pkg::M_TDATA_W-1:0]    m_tdata,
	// match_valid [0]
	output logic                              m_tuser
);

	localparam int WORDS  = (DESC_BYTES + 7) / 8;
	localparam int KEY_AW = $clog2(KEYPOINTS);
	localparam int DIST_W = $clog2(DESC_BYTES * 8 + 1);
	localparam int PROD_W = hntm_pkg::RATIO_W + DIST_W;
	localparam logic [KEY_AW-1:0] LAST_IDX = KEY_AW'(KEYPOINTS - 1);

	// request fields
	logic [hntm_pkg::DESC_WORD_W-1:0] desc_word;
	logic [hntm_pkg::WORD_IDX_W-1:0]  word_index;
	logic [hntm_pkg::ITEM_IDX_W-1:0]  item_index;
	logic                             req_type;
	logic                             accept;
	logic                             item_ok;
	logic                             last_query;

	// configuration
	logic [hntm_pkg::RATIO_W-1:0] ratio_q;
	logic                         cell_mode_q;

	// sequencer
	hntm_pkg::state_t   state_q;
	hntm_pkg::state_t   state_next;
	logic [KEY_AW-1:0]  scan_cnt_q;
	logic               rd_en;
	logic               load_out;
	logic               start;

	// datapath
	logic [WORDS-1:0][hntm_pkg::DESC_WORD_W-1:0] query_q;
	logic [WORDS-1:0][hntm_pkg::DESC_WORD_W-1:0] train_rd;
	hntm_pkg::scan_tag_t  tag_s1;
	logic [KEY_AW-1:0]    idx_s1;
	hntm_pkg::scan_tag_t  tag_s3;
	logic [KEY_AW-1:0]    idx_s3;
	logic [DIST_W-1:0]    dist_s3;
	logic [DIST_W-1:0]    best;
	logic [DIST_W-1:0]    second;
	logic [KEY_AW-1:0]    best_idx;
	logic                 rank_done;

	// result
	logic [hntm_pkg::ITEM_IDX_W-1:0] query_idx_q;
	logic [PROD_W-1:0]               lhs;
	logic [PROD_W-1:0]               rhs;
	logic [hntm_pkg::OUT_DIST_W-1:0] best_sat;
	logic [hntm_pkg::OUT_DIST_W-1:0] second_sat;
	logic                            out_valid_q;
	logic [hntm_pkg::M_TDATA_W-1:0]  out_data_q;
	logic                            out_match_q;

	// unpack the request
	assign desc_word  = s_tdata[63:0];
	assign word_index = s_tdata[65:64];
	assign item_index = s_tdata[74:66];
	assign req_type   = s_tuser;
	assign accept     = s_tvalid && s_tready;
	assign item_ok    = 32'(item_index) < 32'(KEYPOINTS);
	assign last_query = accept && (req_type == hntm_pkg::REQ_QUERY)
		&& (32'(word_index) == WORDS - 1);
	assign start      = last_query;

	// configuration register decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q     <= hntm_pkg::RATIO_RESET;
			cell_mode_q <= hntm_pkg::CELL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hntm_pkg::REG_RATIO: ratio_q     <= cfg_data[hntm_pkg::RATIO_W-1:0];
				hntm_pkg::REG_CELL:  cell_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			hntm_pkg::ST_IDLE: begin
				if (last_query) state_next = hntm_pkg::ST_SCAN;
			end
			hntm_pkg::ST_SCAN: begin
				if (scan_cnt_q == LAST_IDX) state_next = hntm_pkg::ST_DRAIN;
			end
			hntm_pkg::ST_DRAIN: begin
				if (rank_done) state_next = hntm_pkg::ST_RESULT;
			end
			hntm_pkg::ST_RESULT: begin
				if (!out_valid_q || m_tready) state_next = hntm_pkg::ST_IDLE;
			end
			default: state_next = hntm_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			hntm_pkg::ST_IDLE:   s_tready = 1'b1;
			hntm_pkg::ST_SCAN:   rd_en    = 1'b1;
			hntm_pkg::ST_DRAIN:  ;
			hntm_pkg::ST_RESULT: load_out = !out_valid_q || m_tready;
			default: ;
		endcase
	end

	// state and scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= hntm_pkg::ST_IDLE;
			scan_cnt_q <= '0;
		end else begin
			state_q <= state_next;
			if (start) begin
				scan_cnt_q <= '0;
			end else if (rd_en) begin
				scan_cnt_q <= scan_cnt_q + KEY_AW'(1);
			end
		end
	end

	// read tag, lined up with the registered ram data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.valid <= rd_en;
			tag_s1.last  <= rd_en && (scan_cnt_q == LAST_IDX);
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_cnt_q;
	end

	// query words and train stores, one per word position
	for (genvar w = 0; w < WORDS; w++) begin : g_word
		logic sel;
		logic train_we;

		assign sel      = accept && (32'(word_index) == w);
		assign train_we = sel && (req_type == hntm_pkg::REQ_TRAIN) && item_ok;

		always_ff @(posedge clk) begin
			if (sel && req_type == hntm_pkg::REQ_QUERY) begin
				query_q[w] <= desc_word;
			end
		end

		hntm_ram #(
			.WIDTH (hntm_pkg::DESC_WORD_W),
			.DEPTH (KEYPOINTS)
		) u_train (
			.clk   (clk),
			.we    (train_we),
			.waddr (KEY_AW'(item_index)),
			.wdata (desc_word),
			.re    (rd_en),
			.raddr (scan_cnt_q),
			.rdata (train_rd[w])
		);
	end

	// distance lanes
	hntm_dist #(
		.KEYPOINTS  (KEYPOINTS),
		.DESC_BYTES (DESC_BYTES)
	) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.cell_mode (cell_mode_q),
		.query     (query_q),
		.train     (train_rd),
		.tag_s1    (tag_s1),
		.idx_s1    (idx_s1),
		.tag_s3    (tag_s3),
		.idx_s3    (idx_s3),
		.dist_s3   (dist_s3)
	);

	// top-two ranking
	hntm_rank #(
		.KEYPOINTS  (KEYPOINTS),
		.DESC_BYTES (DESC_BYTES)
	) u_rank (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.tag      (tag_s3),
		.idx      (idx_s3),
		.dist_in  (dist_s3),
		.best     (best),
		.second   (second),
		.best_idx (best_idx),
		.done     (rank_done)
	);

	// query index of the scan in flight
	always_ff @(posedge clk) begin
		if (last_query) begin
			query_idx_q <= item_index;
		end
	end

	// ratio test on the unsaturated distances
	assign lhs = PROD_W'(best) << hntm_pkg::FRAC_BITS;
	assign rhs = PROD_W'(ratio_q) * PROD_W'(second);

	// saturate distances for the result
	assign best_sat   = (32'(best) > 32'(hntm_pkg::DIST_SAT))
		? hntm_pkg::DIST_SAT : hntm_pkg::OUT_DIST_W'(best);
	assign second_sat = (32'(second) > 32'(hntm_pkg::DIST_SAT))
		? hntm_pkg::DIST_SAT : hntm_pkg::OUT_DIST_W'(second);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q  <= {4'b0000, second_sat, best_sat,
				hntm_pkg::ITEM_IDX_W'(best_idx), query_idx_q};
			out_match_q <= lhs <= rhs;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_match_q;

endmodule
